// File: sv/dsq_pkg.sv
// ----------------------------------------------------------------------------
// dsq_pkg
// Shared constants, codes and types for the delta sleep queue.
// ----------------------------------------------------------------------------
package dsq_pkg;

  // default sizing
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_TIME_BITS   = 16;
  localparam int DEF_ID_BITS     = 8;

  // fixed port widths
  localparam int IN_ID_BITS   = 8;
  localparam int IN_TIME_BITS = 16;
  localparam int OUT_ID_BITS  = 8;

  // request codes
  localparam logic REQ_SLEEP = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // result kinds
  localparam logic KIND_WOKEN  = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REJ,
    ST_WALK_RD,
    ST_WALK,
    ST_SH_RD,
    ST_SH,
    ST_SUCC,
    ST_PUT,
    ST_T_RD,
    ST_T_DEC,
    ST_T_PEEK_RD,
    ST_T_PEEK,
    ST_T_LAST
  } state_t;

  // operations of the shared subtractor
  typedef enum logic [1:0] {
    ALU_WALK,
    ALU_SUCC,
    ALU_DEC
  } alu_op_t;

  // one result word handed from the sequencer to the output register
  typedef struct packed {
    logic                   valid;
    logic                   kind;
    logic                   last;
    logic [OUT_ID_BITS-1:0] id;
  } emit_t;

endpackage

// File: sv/delta_sleep_queue.sv
// ----------------------------------------------------------------------------
// delta_sleep_queue: delta-encoded timer queue of sleeping thread ids.
// Sleep walks the entries, then appends, or shifts later entries up, fixes
// the successor and inserts; into an empty queue it appends. Tick: decrements
// the head, releases each head entry at zero, and is not busy when empty.
// The single store read port and output stalls set the busy time. One item
// at a time. Reset empties the queue at once; no clearing pass.
// ----------------------------------------------------------------------------
module delta_sleep_queue #(
  parameter int QUEUE_DEPTH = dsq_pkg::DEF_QUEUE_DEPTH,
  parameter int TIME_BITS   = dsq_pkg::DEF_TIME_BITS,
  parameter int ID_BITS     = dsq_pkg::DEF_ID_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               req_type,
  input  logic [dsq_pkg::IN_ID_BITS-1:0]     thread_id,
  input  logic [dsq_pkg::IN_TIME_BITS-1:0]   sleep_ticks,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               kind,
  output logic [dsq_pkg::OUT_ID_BITS-1:0]    woken_id,
  output logic                               last
);

  import dsq_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int EW = TIME_BITS + ID_BITS;

  logic          busy;
  logic          start;
  logic          out_free;
  emit_t         emit;
  logic          we;
  logic [PW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [PW-1:0] raddr;
  logic [EW-1:0] rdata;

  // input side: one word at a time
  assign in_stall = busy;
  assign start    = in_valid && !busy;

  // output register frees when empty or when its word is taken
  assign out_free = !out_valid || !out_stall;

  dsq_seq #(
    .DEPTH (QUEUE_DEPTH),
    .TW    (TIME_BITS),
    .IW    (ID_BITS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .id_in    (ID_BITS'(thread_id)),
    .ticks_in (TIME_BITS'(sleep_ticks)),
    .out_free (out_free),
    .busy     (busy),
    .emit     (emit),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .raddr    (raddr),
    .rdata    (rdata)
  );

  dsq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (emit.valid) begin
      kind     <= emit.kind;
      woken_id <= emit.id;
      last     <= emit.last;
    end
  end

endmodule

// File: sv/dsq_mem.sv
// ----------------------------------------------------------------------------
// dsq_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dsq_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: sv/dsq_alu.sv
// ----------------------------------------------------------------------------
// dsq_alu
// Shared subtractor: walk compare, successor fix-up and head decrement.
// ----------------------------------------------------------------------------
module dsq_alu #(
  parameter int TW = 16
) (
  input  dsq_pkg::alu_op_t op,
  input  logic [TW-1:0]    rem,
  input  logic [TW-1:0]    rd_delta,
  input  logic [TW-1:0]    succ_delta,
  output logic [TW-1:0]    diff,
  output logic             borrow
);

  import dsq_pkg::*;

  logic [TW-1:0] opa;
  logic [TW-1:0] opb;

  // operand selection
  always_comb begin
    unique case (op)
      ALU_WALK: begin
        opa = rem;
        opb = rd_delta;
      end
      ALU_SUCC: begin
        opa = succ_delta;
        opb = rem;
      end
      ALU_DEC: begin
        opa = rd_delta;
        opb = TW'(1);
      end
      default: begin
        opa = rem;
        opb = rd_delta;
      end
    endcase
  end

  // borrow set means opa < opb
  assign {borrow, diff} = {1'b0, opa} - {1'b0, opb};

endmodule

// File: sv/dsq_seq.sv
// ----------------------------------------------------------------------------
// dsq_seq
// Sequencer: walks the queue, shifts entries, inserts or rejects when full, and releases due
// heads on a tick. The queue is a ring in the entry store from head pointer hd.
// ----------------------------------------------------------------------------
module dsq_seq #(
  parameter int DEPTH = 16,
  parameter int TW    = 16,
  parameter int IW    = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     req_type,
  input  logic [IW-1:0]            id_in,
  input  logic [TW-1:0]            ticks_in,
  input  logic                     out_free,
  output logic                     busy,
  output dsq_pkg::emit_t           emit,
  output logic                     we,
  output logic [$clog2(DEPTH)-1:0] waddr,
  output logic [TW+IW-1:0]         wdata,
  output logic [$clog2(DEPTH)-1:0] raddr,
  input  logic [TW+IW-1:0]         rdata
);

  import dsq_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t state, state_next;

  logic [PW-1:0]    hd;
  logic [CW-1:0]    count;
  logic [CW-1:0]    pos;
  logic [CW-1:0]    jw;
  logic [TW-1:0]    rem;
  logic [IW-1:0]    nid;
  logic [TW-1:0]    succ_delta;
  logic [IW-1:0]    succ_id;
  logic [IW-1:0]    pend;

  logic [TW-1:0]    rd_delta;
  logic [IW-1:0]    rd_id;
  alu_op_t          alu_op;
  logic [TW-1:0]    diff;
  logic             borrow;

  logic [CW-1:0]    pos_inc;
  logic             walk_ge;
  logic             head_keeps;

  // logical index to ring address
  function automatic logic [PW-1:0] phys(input logic [CW-1:0] idx);
    logic [CW:0] sum;
    sum = (CW+1)'(hd) + (CW+1)'(idx);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  assign rd_delta   = rdata[TW+IW-1:IW];
  assign rd_id      = rdata[IW-1:0];
  assign pos_inc    = pos + CW'(1);
  assign walk_ge    = !borrow;
  assign head_keeps = (rd_delta != '0) && (diff != '0);
  assign busy       = (state != ST_IDLE);

  dsq_alu #(
    .TW(TW)
  ) u_alu (
    .op         (alu_op),
    .rem        (rem),
    .rd_delta   (rd_delta),
    .succ_delta (succ_delta),
    .diff       (diff),
    .borrow     (borrow)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (req_type == REQ_TICK) begin
            state_next = (count == '0) ? ST_IDLE : ST_T_RD;
          end else if (count == CW'(DEPTH)) begin
            state_next = ST_REJ;
          end else if (count == '0) begin
            state_next = ST_PUT;
          end else begin
            state_next = ST_WALK_RD;
          end
        end
      end
      ST_REJ: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_WALK_RD: state_next = ST_WALK;
      ST_WALK: begin
        if (walk_ge) begin
          state_next = (pos_inc == count) ? ST_PUT : ST_WALK;
        end else begin
          state_next = (count > pos_inc) ? ST_SH_RD : ST_SUCC;
        end
      end
      ST_SH_RD: state_next = ST_SH;
      ST_SH: begin
        if (jw == pos + CW'(2)) state_next = ST_SUCC;
      end
      ST_SUCC: state_next = ST_PUT;
      ST_PUT:  state_next = ST_IDLE;
      ST_T_RD: state_next = ST_T_DEC;
      ST_T_DEC: begin
        if (head_keeps) begin
          state_next = ST_IDLE;
        end else begin
          state_next = (count != CW'(1)) ? ST_T_PEEK_RD : ST_T_LAST;
        end
      end
      ST_T_PEEK_RD: state_next = ST_T_PEEK;
      ST_T_PEEK: begin
        if (out_free) begin
          if (rd_delta != '0) begin
            state_next = ST_IDLE;
          end else begin
            state_next = (count != CW'(1)) ? ST_T_PEEK_RD : ST_T_LAST;
          end
        end
      end
      ST_T_LAST: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // store ports, subtractor operation and result words
  always_comb begin
    raddr  = phys('0);
    we     = 1'b0;
    waddr  = phys(pos);
    wdata  = {rem, nid};
    alu_op = ALU_WALK;
    emit   = '0;
    unique case (state)
      ST_REJ: begin
        emit.valid = out_free;
        emit.kind  = KIND_REJECT;
        emit.last  = 1'b1;
        emit.id    = OUT_ID_BITS'(nid);
      end
      ST_WALK_RD: raddr = phys(pos);
      ST_WALK: begin
        // fetch the next entry ahead of the compare
        raddr  = phys(pos_inc);
        alu_op = ALU_WALK;
      end
      ST_SH_RD: raddr = phys(count - CW'(1));
      ST_SH: begin
        we    = 1'b1;
        waddr = phys(jw);
        wdata = rdata;
        raddr = phys(jw - CW'(2));
      end
      ST_SUCC: begin
        alu_op = ALU_SUCC;
        we     = 1'b1;
        waddr  = phys(pos_inc);
        wdata  = {diff, succ_id};
      end
      ST_PUT: begin
        we    = 1'b1;
        waddr = phys(pos);
        wdata = {rem, nid};
      end
      ST_T_DEC: begin
        alu_op = ALU_DEC;
        we     = head_keeps;
        waddr  = phys('0);
        wdata  = {diff, rd_id};
      end
      ST_T_PEEK: begin
        emit.valid = out_free;
        emit.kind  = KIND_WOKEN;
        emit.last  = (rd_delta != '0);
        emit.id    = OUT_ID_BITS'(pend);
      end
      ST_T_LAST: begin
        emit.valid = out_free;
        emit.kind  = KIND_WOKEN;
        emit.last  = 1'b1;
        emit.id    = OUT_ID_BITS'(pend);
      end
      default: begin
        raddr = phys('0);
      end
    endcase
  end

  // state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      hd    <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            nid <= id_in;
            rem <= ticks_in;
            pos <= '0;
          end
        end
        ST_WALK: begin
          if (walk_ge) begin
            rem <= diff;
            pos <= pos_inc;
          end else begin
            succ_delta <= rd_delta;
            succ_id    <= rd_id;
            jw         <= count;
          end
        end
        ST_SH: jw <= jw - CW'(1);
        ST_PUT: count <= count + CW'(1);
        ST_T_DEC: begin
          if (!head_keeps) begin
            pend  <= rd_id;
            hd    <= phys(CW'(1));
            count <= count - CW'(1);
          end
        end
        ST_T_PEEK: begin
          if (out_free && (rd_delta == '0)) begin
            pend  <= rd_id;
            hd    <= phys(CW'(1));
            count <= count - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: sv/dsq_chk.sv
// ----------------------------------------------------------------------------
// dsq_chk
// Port-level checks for the delta sleep queue, bound to the top level.
// ----------------------------------------------------------------------------
module dsq_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            req_type,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            kind,
  input logic [dsq_pkg::OUT_ID_BITS-1:0] woken_id,
  input logic                            last
);

  import dsq_pkg::*;

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(woken_id) && $stable(kind)
      && $stable(last))
    else $error("stalled output word changed");

  // a rejection is the only word of its request
  a_rej_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_REJECT) |-> last)
    else $error("rejection without last");

  // a sleep request always keeps the block busy for a while
  a_sleep_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (req_type == REQ_SLEEP) |=> in_stall)
    else $error("sleep request did not occupy the block");

  // words are produced only while an item is in work
  a_out_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("output word appeared while idle");

endmodule

bind delta_sleep_queue dsq_chk u_chk (.*);

// File: dv/delta_sleep_queue_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delta_sleep_queue_test
// Feeds sleep requests and timer ticks into the delta sleep queue with random
// gaps and output back-pressure. A software copy of the queue forecasts every
// woken or rejected word, and each word leaving the block is compared field by
// field with the oldest forecast.
// ----------------------------------------------------------------------------
module delta_sleep_queue_test;
  import dsq_pkg::*;

  localparam int  QDEPTH        = DEF_QUEUE_DEPTH;
  localparam int  TBITS         = DEF_TIME_BITS;
  localparam int  IBITS         = DEF_ID_BITS;
  localparam real CLK_PERIOD    = 12.0;
  localparam int  RANDOM_WORDS  = 360;
  localparam int  SETTLE_CYCLES = 48;
  localparam int  LIMIT_CYCLES  = 400_000;

  // one forecast result word
  typedef struct packed {
    logic                   kind;
    logic [OUT_ID_BITS-1:0] id;
    logic                   last;
  } wake_word_t;

  // software copy of the queue plus the words it says are still to come
  class wake_forecast;
    logic [TBITS-1:0] delta_q [QDEPTH];
    logic [IBITS-1:0] id_q [QDEPTH];
    int               used;
    wake_word_t       due_words [$];
    int               errors;

    function new();
      used   = 0;
      errors = 0;
    endfunction

    // update the copy for an accepted request and queue the words it causes
    function void note_request(logic req, logic [IN_ID_BITS-1:0] tid,
                               logic [IN_TIME_BITS-1:0] ticks);
      logic [TBITS-1:0] remain;
      logic [IBITS-1:0] sid;
      wake_word_t       tail;
      int               pos;
      int               first;
      remain = ticks[TBITS-1:0];
      sid    = tid[IBITS-1:0];
      if (req == REQ_SLEEP) begin
        // full queue: request bounces straight back
        if (used >= QDEPTH) begin
          due_words.push_back({KIND_REJECT, OUT_ID_BITS'(sid), 1'b1});
          return;
        end
        // walk past every entry due no later than this one
        pos = 0;
        while (pos < used && remain >= delta_q[pos]) begin
          remain -= delta_q[pos];
          pos++;
        end
        for (int j = used; j > pos; j--) begin
          delta_q[j] = delta_q[j-1];
          id_q[j]    = id_q[j-1];
        end
        delta_q[pos] = remain;
        id_q[pos]    = sid;
        used++;
        // successor now waits relative to the new entry
        if (pos + 1 < used) delta_q[pos+1] = delta_q[pos+1] - remain;
      end else if (used != 0) begin
        if (delta_q[0] != '0) delta_q[0] = delta_q[0] - 1'b1;
        first = due_words.size();
        // release every head entry that has reached zero
        while (used > 0 && delta_q[0] == '0) begin
          due_words.push_back({KIND_WOKEN, OUT_ID_BITS'(id_q[0]), 1'b0});
          for (int j = 1; j < used; j++) begin
            delta_q[j-1] = delta_q[j];
            id_q[j-1]    = id_q[j];
          end
          used--;
        end
        if (due_words.size() > first) begin
          tail      = due_words.pop_back();
          tail.last = 1'b1;
          due_words.push_back(tail);
        end
      end
    endfunction

    function void compare_field(string label, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t ns: %s expected %0d, got %0d", $time, label, want, got);
      end
    endfunction

    // check one word taken from the block against the oldest forecast
    function void check_word(logic k, logic [OUT_ID_BITS-1:0] id, logic l);
      wake_word_t want;
      if (due_words.size() == 0) begin
        errors++;
        $display("%0t ns: word with nothing expected, got kind %0d id %0d last %0d",
                 $time, k, id, l);
        return;
      end
      want = due_words.pop_front();
      compare_field("kind", 8'(want.kind), 8'(k));
      compare_field("woken_id", 8'(want.id), 8'(id));
      compare_field("last", 8'(want.last), 8'(l));
    endfunction
  endclass

  logic                    clk;
  logic                    rst         = 1'b1;
  logic                    in_valid    = 1'b0;
  logic                    in_stall;
  logic                    req_type    = REQ_TICK;
  logic [IN_ID_BITS-1:0]   thread_id   = '0;
  logic [IN_TIME_BITS-1:0] sleep_ticks = '0;
  logic                    out_valid;
  logic                    out_stall   = 1'b0;
  logic                    kind;
  logic [OUT_ID_BITS-1:0]  woken_id;
  logic                    last;
  bit                      steady      = 1'b0;
  wake_forecast            board       = new();

  delta_sleep_queue #(
    .QUEUE_DEPTH (QDEPTH),
    .TIME_BITS   (TBITS),
    .ID_BITS     (IBITS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .thread_id   (thread_id),
    .sleep_ticks (sleep_ticks),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .woken_id    (woken_id),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2.0) clk = ~clk;
  end

  // random back-pressure on the result side
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 28);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      board.check_word(kind, woken_id, last);
    end
  end

  // present one word, hold it until taken; returns at the following falling edge
  task automatic send_word(logic req, logic [IN_ID_BITS-1:0] tid,
                           logic [IN_TIME_BITS-1:0] ticks);
    while (!steady && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= req;
    thread_id   <= tid;
    sleep_ticks <= ticks;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.note_request(req, tid, ticks);
    @(negedge clk);
  endtask

  // stop sending, wait for every forecast word, then let the block go quiet
  task automatic settle_queue();
    in_valid <= 1'b0;
    while (board.due_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int                      sleep_pct;
    int                      big_left;
    logic [IN_TIME_BITS-1:0] ticks;
    sleep_pct = 50;
    big_left  = 3;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // directed: tick on empty queue, zero and maximal waits, tied wake times
    send_word(REQ_TICK, 8'hFF, 16'hFFFF);
    send_word(REQ_SLEEP, 8'h00, 16'h0000);
    send_word(REQ_SLEEP, 8'hFF, 16'hFFFF);
    send_word(REQ_SLEEP, 8'h5A, 16'd2);
    send_word(REQ_SLEEP, 8'hA5, 16'd2);
    send_word(REQ_TICK, 8'h00, 16'h0000);   // zero-wait thread goes
    send_word(REQ_TICK, 8'h3C, 16'h1234);   // nothing due, head counts down
    send_word(REQ_TICK, 8'hC3, 16'hEDCB);   // tie released in arrival order
    // fill up with one shared wake time, bounce the last, release them in one go
    for (int k = 0; k < QDEPTH; k++) send_word(REQ_SLEEP, 8'(8'h10 + k), 16'd1);
    send_word(REQ_TICK, 8'h96, 16'h6969);
    settle_queue();

    // random: sleep share varies so the queue both drains and fills
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 60 == 0) sleep_pct = $urandom_range(30, 75);
      steady = (n >= 120 && n < 190);
      if (n == 240) settle_queue();
      if ($urandom_range(0, 99) < sleep_pct) begin
        if (big_left > 0 && $urandom_range(0, 99) == 0) begin
          ticks = 16'($urandom);
          big_left--;
        end else if ($urandom_range(0, 3) == 0) begin
          ticks = 16'($urandom_range(0, 12));
        end else begin
          ticks = 16'($urandom_range(0, 3));
        end
        send_word(REQ_SLEEP, 8'($urandom), ticks);
      end else begin
        send_word(REQ_TICK, 8'($urandom), 16'($urandom));
      end
    end
    steady = 1'b0;
    settle_queue();

    if (board.errors == 0) begin
      $display("delta_sleep_queue test passed");
    end else begin
      $display("delta_sleep_queue test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("delta_sleep_queue test failed");
    $finish;
  end

endmodule
